@@ rtl/tbsq_pkg.sv @@
package tbsq_pkg;

    // Queue and token sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int TOKEN_WIDTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_W       = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    localparam logic [TOKEN_WIDTH-1:0] DEPTH_RESET = TOKEN_WIDTH'(10);

    // Word kinds
    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOKEN_ADDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOKEN_DROP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSHED     = 3'd5;

    typedef struct packed {
        logic [NUM_W-1:0]       number;
        logic [TOKEN_WIDTH-1:0] need;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_fifo_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             head_avail;
    } t_fifo_stat;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [NUM_W-1:0]       packet_number;
        logic [TOKEN_WIDTH-1:0] bucket_level;
        logic                   release_valid;
        logic [NUM_W-1:0]       release_number;
        logic [TOKEN_WIDTH-1:0] release_tokens;
        logic [CNT_W-1:0]       removed_count;
    } t_result;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

@@ rtl/tbsq_fifo.sv @@
module tbsq_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbsq_pkg::t_fifo_ctl i_ctl,
    input  tbsq_pkg::t_entry    i_push_entry,
    output tbsq_pkg::t_fifo_stat o_stat,
    output tbsq_pkg::t_entry    o_head
);
    import tbsq_pkg::*;

    t_entry           r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // Status; an empty queue forwards the word being pushed as its head
    always_comb begin
        o_stat.count      = r_count;
        o_stat.full       = (r_count == CNT_FULL);
        o_stat.head_avail = (r_count != '0) || i_ctl.push;
        o_head            = (r_count == '0) ? i_push_entry : r_store[r_head];
    end

    // Pointer and count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.flush) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else begin
            if (i_ctl.push) begin
                n_tail = ptr_advance(r_tail);
            end
            if (i_ctl.pop) begin
                n_head = ptr_advance(r_head);
            end
            n_count = r_count + CNT_W'(i_ctl.push) - CNT_W'(i_ctl.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry store, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[r_tail] <= i_push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> (r_count != CNT_FULL))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> ((r_count != '0) || i_ctl.push))
        else $error("pop with no head word");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with pointers apart");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flush |=> (r_count == '0))
        else $error("flush left words in queue");

endmodule

@@ rtl/tbsq_shaper.sv @@
module tbsq_shaper (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [tbsq_pkg::TOKEN_WIDTH-1:0]      i_cfg_wr_data,
    input  logic                                  i_step,
    input  logic [tbsq_pkg::KIND_W-1:0]           i_kind,
    input  logic [tbsq_pkg::TOKEN_WIDTH-1:0]      i_need,
    input  tbsq_pkg::t_fifo_stat                  i_fifo_stat,
    input  tbsq_pkg::t_entry                      i_head,
    output tbsq_pkg::t_fifo_ctl                   o_fifo_ctl,
    output tbsq_pkg::t_entry                      o_push_entry,
    output tbsq_pkg::t_result                     o_result
);
    import tbsq_pkg::*;

    logic [TOKEN_WIDTH-1:0] r_depth;
    logic [TOKEN_WIDTH-1:0] r_level, n_level;
    logic [NUM_W-1:0]       r_next_num, n_next_num;

    logic                   arrival, tick, flush;
    logic                   too_big;
    logic [NUM_W-1:0]       num_inc;
    logic [TOKEN_WIDTH-1:0] level_mid;
    logic                   tick_ok;
    logic                   release_go;

    // Kind decode
    always_comb begin
        arrival = 1'b0;
        tick    = 1'b0;
        flush   = 1'b0;
        unique case (i_kind)
            KIND_ARRIVAL: arrival = i_step;
            KIND_TICK:    tick    = i_step;
            KIND_FLUSH:   flush   = i_step;
            default: ;
        endcase
    end

    // Admission, token add, head release
    always_comb begin
        num_inc    = r_next_num + NUM_W'(1);
        too_big    = (i_need > r_depth);
        tick_ok    = (r_level < r_depth);
        level_mid  = (tick && tick_ok) ? r_level + TOKEN_WIDTH'(1) : r_level;

        o_fifo_ctl.flush = flush;
        o_fifo_ctl.push  = arrival && !too_big && !i_fifo_stat.full;
        o_push_entry.number = num_inc;
        o_push_entry.need   = i_need;

        release_go = (arrival || tick) && i_fifo_stat.head_avail
                     && (level_mid >= i_head.need);
        o_fifo_ctl.pop = release_go;

        n_level    = release_go ? level_mid - i_head.need : level_mid;
        n_next_num = arrival ? num_inc : r_next_num;
    end

    // Result word
    always_comb begin
        o_result = '0;
        if (arrival) begin
            o_result.packet_number = num_inc;
            if (too_big) begin
                o_result.status = ST_DROPPED;
            end else if (i_fifo_stat.full) begin
                o_result.status = ST_REJECTED;
            end else begin
                o_result.status = ST_QUEUED;
            end
        end else if (tick) begin
            o_result.status = tick_ok ? ST_TOKEN_ADDED : ST_TOKEN_DROP;
        end else begin
            o_result.status        = ST_FLUSHED;
            o_result.removed_count = i_fifo_stat.count;
        end
        o_result.bucket_level = n_level;
        if (release_go) begin
            o_result.release_valid  = 1'b1;
            o_result.release_number = i_head.number;
            o_result.release_tokens = i_head.need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= DEPTH_RESET;
            r_level    <= '0;
            r_next_num <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth <= i_cfg_wr_data;
            end
            r_level    <= n_level;
            r_next_num <= n_next_num;
        end
    end

endmodule

@@ rtl/token_bucket_shaper_queue.sv @@
// Token bucket shaper with a 16-entry packet queue. Each input word is a packet
// arrival, a token tick or a flush; kind 3 is taken and produces no result. One
// word is accepted every cycle when the result side keeps up. Each word is held
// in the input register, then makes one pass through the bucket and queue logic
// into the result register. The token level, packet counter and queue pointers
// all update in that single pass, so there is no hazard between consecutive
// words. At most one queued packet is released per word. The bucket depth
// register may only be written while no word is in flight.
module token_bucket_shaper_queue (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [tbsq_pkg::TOKEN_WIDTH-1:0]      i_cfg_wr_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [tbsq_pkg::KIND_W-1:0]           i_kind,
    input  logic [tbsq_pkg::TOKEN_WIDTH-1:0]      i_tokens_needed,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tbsq_pkg::STATUS_W-1:0]         o_status,
    output logic [tbsq_pkg::NUM_W-1:0]            o_packet_number,
    output logic [tbsq_pkg::TOKEN_WIDTH-1:0]      o_bucket_level,
    output logic                                  o_release_valid,
    output logic [tbsq_pkg::NUM_W-1:0]            o_release_number,
    output logic [tbsq_pkg::TOKEN_WIDTH-1:0]      o_release_tokens,
    output logic [tbsq_pkg::CNT_W-1:0]            o_removed_count
);
    import tbsq_pkg::*;

    logic                   r_in_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [TOKEN_WIDTH-1:0] r_need;
    logic                   r_out_valid;
    t_result                r_result;

    logic       out_free;
    logic       consume;
    logic       load_out;
    t_fifo_ctl  fifo_ctl;
    t_fifo_stat fifo_stat;
    t_entry     push_entry;
    t_entry     head_entry;
    t_result    result;

    // Handshake between input register and result register
    assign out_free   = !r_out_valid || i_out_ready;
    assign consume    = r_in_valid && (out_free || (r_kind == KIND_UNUSED));
    assign load_out   = consume && (r_kind != KIND_UNUSED);
    assign o_in_ready = !r_in_valid || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_need <= i_tokens_needed;
        end
    end

    tbsq_shaper u_shaper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (consume),
        .i_kind        (r_kind),
        .i_need        (r_need),
        .i_fifo_stat   (fifo_stat),
        .i_head        (head_entry),
        .o_fifo_ctl    (fifo_ctl),
        .o_push_entry  (push_entry),
        .o_result      (result)
    );

    tbsq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (fifo_ctl),
        .i_push_entry (push_entry),
        .o_stat       (fifo_stat),
        .o_head       (head_entry)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_packet_number  = r_result.packet_number;
    assign o_bucket_level   = r_result.bucket_level;
    assign o_release_valid  = r_result.release_valid;
    assign o_release_number = r_result.release_number;
    assign o_release_tokens = r_result.release_tokens;
    assign o_removed_count  = r_result.removed_count;

    a_flush_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.status == ST_FLUSHED)) |-> !r_result.release_valid)
        else $error("release reported on flush");

    a_removed_only_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.removed_count != '0))
            |-> (r_result.status == ST_FLUSHED))
        else $error("removed count on non-flush word");

    a_unused_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && (r_kind == KIND_UNUSED) && !r_out_valid) |=> !r_out_valid)
        else $error("result produced for unused kind");

endmodule

@@ test/token_bucket_shaper_queue_test.sv @@
`timescale 1ns / 100ps

module token_bucket_shaper_queue_test;
    import tbsq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Block ports
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [TOKEN_WIDTH-1:0] i_cfg_wr_data   = '0;
    logic                   i_in_valid      = 1'b0;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      i_kind          = KIND_TICK;
    logic [TOKEN_WIDTH-1:0] i_tokens_needed = '0;
    logic                   o_out_valid;
    logic                   i_out_ready     = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [NUM_W-1:0]       o_packet_number;
    logic [TOKEN_WIDTH-1:0] o_bucket_level;
    logic                   o_release_valid;
    logic [NUM_W-1:0]       o_release_number;
    logic [TOKEN_WIDTH-1:0] o_release_tokens;
    logic [CNT_W-1:0]       o_removed_count;

    // Shaper state as the testbench sees it
    logic [TOKEN_WIDTH-1:0] bucket_cap;
    logic [TOKEN_WIDTH-1:0] bucket_tokens;
    logic [NUM_W-1:0]       last_packet;
    t_entry                 fifo_mem [QUEUE_DEPTH];
    int                     fifo_head;
    int                     fifo_tail;
    int                     fifo_fill;

    t_result results_due [$];
    t_result want;
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 31;
    int      recv_idle_pct  = 66;

    token_bucket_shaper_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_tokens_needed  (i_tokens_needed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_packet_number  (o_packet_number),
        .o_bucket_level   (o_bucket_level),
        .o_release_valid  (o_release_valid),
        .o_release_number (o_release_number),
        .o_release_tokens (o_release_tokens),
        .o_removed_count  (o_removed_count)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("token_bucket_shaper_queue_test NOT OK");
            $finish;
        end
    end

    // Predicts the result of one word; returns 0 when the word yields none
    function automatic bit shape_word(input logic [KIND_W-1:0] kind,
                                      input logic [TOKEN_WIDTH-1:0] need,
                                      output t_result res);
        res = '0;
        if (kind == KIND_UNUSED) begin
            return 1'b0;
        end
        case (kind)
            KIND_ARRIVAL: begin
                // every arrival takes a number, even when it is turned away
                last_packet       = last_packet + NUM_W'(1);
                res.packet_number = last_packet;
                if (need > bucket_cap) begin
                    res.status = ST_DROPPED;
                end else if (fifo_fill == QUEUE_DEPTH) begin
                    res.status = ST_REJECTED;
                end else begin
                    fifo_mem[fifo_tail].number = last_packet;
                    fifo_mem[fifo_tail].need   = need;
                    fifo_tail  = (fifo_tail + 1) % QUEUE_DEPTH;
                    fifo_fill++;
                    res.status = ST_QUEUED;
                end
            end
            KIND_TICK: begin
                if (bucket_tokens >= bucket_cap) begin
                    res.status = ST_TOKEN_DROP;
                end else begin
                    bucket_tokens = bucket_tokens + TOKEN_WIDTH'(1);
                    res.status    = ST_TOKEN_ADDED;
                end
            end
            default: begin
                res.removed_count = CNT_W'(fifo_fill);
                fifo_fill  = 0;
                fifo_head  = 0;
                fifo_tail  = 0;
                res.status = ST_FLUSHED;
            end
        endcase
        // head check, skipped on a flush
        if (kind != KIND_FLUSH && fifo_fill > 0 &&
            bucket_tokens >= fifo_mem[fifo_head].need) begin
            res.release_valid  = 1'b1;
            res.release_number = fifo_mem[fifo_head].number;
            res.release_tokens = fifo_mem[fifo_head].need;
            bucket_tokens      = bucket_tokens - fifo_mem[fifo_head].need;
            fifo_head          = (fifo_head + 1) % QUEUE_DEPTH;
            fifo_fill--;
        end
        res.bucket_level = bucket_tokens;
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [NUM_W-1:0] exp_v,
                                 input logic [NUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls, each accepted word checked against the oldest prediction
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result word with no prediction pending");
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                compare_field("status", NUM_W'(want.status), NUM_W'(o_status));
                compare_field("packet_number", want.packet_number, o_packet_number);
                compare_field("bucket_level", NUM_W'(want.bucket_level),
                              NUM_W'(o_bucket_level));
                compare_field("release_valid", NUM_W'(want.release_valid),
                              NUM_W'(o_release_valid));
                compare_field("release_number", want.release_number, o_release_number);
                compare_field("release_tokens", NUM_W'(want.release_tokens),
                              NUM_W'(o_release_tokens));
                compare_field("removed_count", NUM_W'(want.removed_count),
                              NUM_W'(o_removed_count));
            end
        end
    end

    // Sends one word, holding it until the block takes it
    task automatic send_word(input logic [KIND_W-1:0] kind,
                             input logic [TOKEN_WIDTH-1:0] need);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_tokens_needed <= need;
        do @(posedge i_clk); while (!o_in_ready);
        if (shape_word(kind, need, res)) begin
            results_due.push_back(res);
        end
    endtask

    // Sender holds off until every predicted word is back, then lets the pipe empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_bucket_cap(input logic [TOKEN_WIDTH-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        bucket_cap = value;
    endtask

    // Needs mostly within the bucket, some at or past its edge, some anywhere
    function automatic logic [TOKEN_WIDTH-1:0] pick_need();
        int unsigned sel;
        int unsigned top;
        sel = $urandom_range(99);
        top = (bucket_cap < 8) ? bucket_cap : 8;
        if (sel < 10) return '0;
        if (sel < 20) return bucket_cap;
        if (sel < 30) return TOKEN_WIDTH'($urandom_range(16'hFFFF, 0));
        if (sel < 38 && bucket_cap != 16'hFFFF) return bucket_cap + TOKEN_WIDTH'(1);
        return TOKEN_WIDTH'($urandom_range(top, 0));
    endfunction

    // Random words; unused kinds do not count toward the total
    task automatic run_random(input int words, input int arrival_pct);
        int          sent;
        int unsigned sel;
        sent = 0;
        while (sent < words) begin
            sel = $urandom_range(99);
            if (sel < 3) begin
                send_word(KIND_FLUSH, TOKEN_WIDTH'($urandom()));
                sent++;
            end else if (sel < 6) begin
                send_word(KIND_UNUSED, TOKEN_WIDTH'($urandom()));
            end else if (sel < 6 + arrival_pct) begin
                send_word(KIND_ARRIVAL, pick_need());
                sent++;
            end else begin
                send_word(KIND_TICK, TOKEN_WIDTH'($urandom()));
                sent++;
            end
        end
    endtask

    // Reset depth: zero need released at once, oversize drops, unused kind, empty flush
    task automatic test_zero_need_and_oversize();
        send_word(KIND_ARRIVAL, 16'd0);
        send_word(KIND_ARRIVAL, 16'hFFFF);
        send_word(KIND_ARRIVAL, 16'd11);
        send_word(KIND_UNUSED, 16'hFFFF);
        send_word(KIND_FLUSH, 16'd0);
    endtask

    // Small bucket: queued packet waits for tokens, then the bucket saturates
    task automatic test_release_and_tick_drop();
        set_bucket_cap(16'd3);
        send_word(KIND_ARRIVAL, 16'd2);
        repeat (6) send_word(KIND_TICK, 16'd0);
    endtask

    // Depth lowered below the level: tokens kept, ticks dropped
    task automatic test_depth_lowered();
        set_bucket_cap(16'd1);
        send_word(KIND_TICK, 16'd0);
        send_word(KIND_ARRIVAL, 16'd1);
        send_word(KIND_ARRIVAL, 16'd2);
        send_word(KIND_TICK, 16'd0);
        send_word(KIND_ARRIVAL, 16'd1);
        send_word(KIND_FLUSH, 16'd0);
    endtask

    // Largest depth: big needs stay queued until a flush removes them
    task automatic test_max_depth();
        set_bucket_cap(16'hFFFF);
        send_word(KIND_ARRIVAL, 16'hFFFF);
        send_word(KIND_ARRIVAL, 16'h8000);
        send_word(KIND_TICK, 16'hFFFF);
        send_word(KIND_FLUSH, 16'hFFFF);
    endtask

    // One idling setting, three depth settings, normal and arrival-heavy traffic
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [TOKEN_WIDTH-1:0] first_cap);
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_bucket_cap(first_cap);
        run_random(110, 45);
        set_bucket_cap(TOKEN_WIDTH'($urandom_range(16, 2)));
        run_random(110, 70);
        set_bucket_cap(TOKEN_WIDTH'($urandom_range(16'hFFFF, 1)));
        run_random(110, 40);
    endtask

    initial begin
        bucket_cap    = DEPTH_RESET;
        bucket_tokens = '0;
        last_packet   = '0;
        fifo_head     = 0;
        fifo_tail     = 0;
        fifo_fill     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_need_and_oversize();
        test_release_and_tick_drop();
        test_depth_lowered();
        test_max_depth();
        test_random_traffic(31, 66, 16'd1);
        test_random_traffic(66, 31, 16'hFFFF);
        test_random_traffic(0, 0, 16'd10);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("token_bucket_shaper_queue_test OK");
        end else begin
            $display("token_bucket_shaper_queue_test NOT OK");
        end
        $finish;
    end

endmodule
